[rtl/core/koc_pkg.sv]
// Shared types and constants for the key occurrence counter.
// No dependencies; every other file of the block imports this package.
package koc_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int KEY_W       = 32;
	localparam int CNT_W       = 31;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int TOT_W       = $clog2(TABLE_DEPTH + 1);

	// saturation ceiling of a count
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [1:0] {
		CMD_COUNT = 2'd0,
		CMD_MERGE = 2'd1,
		CMD_FLUSH = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_SAT   = 2'd2,
		STAT_EMPTY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_INSERT,
		S_FLUSH_RD,
		S_FLUSH_EMIT,
		S_OUT
	} state_t;

	// write request to the key/count table
	typedef struct packed {
		logic                    key_we;
		logic                    cnt_we;
		logic [IDX_W-1:0]        addr;
		logic signed [KEY_W-1:0] key;
		logic [CNT_W-1:0]        count;
	} tbl_wr_t;

endpackage

[rtl/core/koc_req_if.sv]
// Request channel of the key occurrence counter: command, key and amount.
// Depends on koc_pkg.
interface koc_req_if import koc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              command;
	logic signed [KEY_W-1:0] key;
	logic [CNT_W-1:0]        amount;

	modport source (output valid, command, key, amount, input ready);
	modport sink   (input valid, command, key, amount, output ready);
endinterface

[rtl/core/koc_rsp_if.sv]
// Result channel of the key occurrence counter: status, key, count, last.
// Depends on koc_pkg.
interface koc_rsp_if import koc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              status;
	logic signed [KEY_W-1:0] out_key;
	logic [CNT_W-1:0]        out_count;
	logic                    last;

	modport source (output valid, status, out_key, out_count, last, input ready);
	modport sink   (input valid, status, out_key, out_count, last, output ready);
endinterface

[rtl/core/koc_table.sv]
// Key and count storage: one write port, one read port with registered data.
// Depends on koc_pkg.
module koc_table import koc_pkg::*; (
	input  logic                    clk,
	input  tbl_wr_t                 wr,
	input  logic [IDX_W-1:0]        rd_addr,
	output logic signed [KEY_W-1:0] rd_key,
	output logic [CNT_W-1:0]        rd_count
);

	logic signed [KEY_W-1:0] key_mem [TABLE_DEPTH];
	logic [CNT_W-1:0]        cnt_mem [TABLE_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr.key_we) begin
			key_mem[wr.addr] <= wr.key;
		end
		if (wr.cnt_we) begin
			cnt_mem[wr.addr] <= wr.count;
		end
	end

	// read port, data registered: it appears in the cycle after the address
	always_ff @(posedge clk) begin
		rd_key   <= key_mem[rd_addr];
		rd_count <= cnt_mem[rd_addr];
	end

endmodule

[rtl/core/key_occurrence_counter.sv]
// Key occurrence counter: top level with the lookup sequencer and result register.
// Depends on koc_pkg, koc_req_if, koc_rsp_if and koc_table.
//
// Keeps up to TABLE_DEPTH distinct keys with saturating counts in one table
// memory that has a single read port with registered data. A count or merge
// beat scans the stored entries in insertion order, each entry examined in
// two steps (address, then compare and add in one shared adder); a miss
// inserts the key after the last entry unless the table is full. A flush beat
// emits the stored entries in insertion order, then empties the table. One
// beat is worked on at a time; req.ready is high only while the block is
// idle. The result register holds each result until it is taken.
module key_occurrence_counter import koc_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	koc_req_if.sink   req,
	koc_rsp_if.source rsp
);

	state_t                  state_q, state_d;
	logic [IDX_W-1:0]        idx_q, idx_d;
	logic [TOT_W-1:0]        total_q, total_d;
	cmd_t                    cmd_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CNT_W-1:0]        add_q;

	logic                    out_load;
	logic [1:0]              status_d;
	logic signed [KEY_W-1:0] out_key_d;
	logic [CNT_W-1:0]        out_count_d;
	logic                    last_d;
	logic [1:0]              status_q;
	logic signed [KEY_W-1:0] out_key_q;
	logic [CNT_W-1:0]        out_count_q;
	logic                    last_q;

	tbl_wr_t                 wr;
	logic signed [KEY_W-1:0] rd_key;
	logic [CNT_W-1:0]        rd_count;
	logic [CNT_W:0]          sum;
	logic                    at_end;
	logic                    req_fire;

	koc_table u_table (
		.clk      (clk),
		.wr       (wr),
		.rd_addr  (idx_q),
		.rd_key   (rd_key),
		.rd_count (rd_count)
	);

	assign req_fire = req.valid && req.ready;
	// shared adder for count updates
	assign sum      = {1'b0, rd_count} + {1'b0, add_q};
	// current entry is the last one in use
	assign at_end   = ({1'b0, idx_q} + TOT_W'(1)) == total_q;

	assign rsp.valid     = (state_q == S_OUT);
	assign rsp.status    = status_q;
	assign rsp.out_key   = out_key_q;
	assign rsp.out_count = out_count_q;
	assign rsp.last      = last_q;

	// sequencer: next state, table access and result load
	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		total_d     = total_q;
		req.ready   = 1'b0;
		wr          = '0;
		out_load    = 1'b0;
		status_d    = STAT_OK;
		out_key_d   = key_q;
		out_count_d = '0;
		last_d      = 1'b1;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				idx_d     = '0;
				if (req_fire) begin
					case (req.command)
						CMD_COUNT, CMD_MERGE: begin
							state_d = (total_q == '0) ? S_INSERT : S_SCAN_RD;
						end
						CMD_FLUSH: begin
							if (total_q == '0) begin
								out_load  = 1'b1;
								status_d  = STAT_EMPTY;
								out_key_d = '0;
								state_d   = S_OUT;
							end else begin
								state_d = S_FLUSH_RD;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_SCAN_RD: state_d = S_SCAN_CMP;
			S_SCAN_CMP: begin
				if (rd_key == key_q) begin
					wr.cnt_we   = 1'b1;
					wr.addr     = idx_q;
					out_load    = 1'b1;
					if (sum[CNT_W]) begin
						out_count_d = CNT_MAX;
						status_d    = STAT_SAT;
					end else begin
						out_count_d = sum[CNT_W-1:0];
					end
					wr.count = out_count_d;
					state_d  = S_OUT;
				end else if (at_end) begin
					state_d = S_INSERT;
				end else begin
					idx_d   = idx_q + IDX_W'(1);
					state_d = S_SCAN_RD;
				end
			end
			S_INSERT: begin
				out_load = 1'b1;
				state_d  = S_OUT;
				if (total_q == TOT_W'(TABLE_DEPTH)) begin
					status_d = STAT_FULL;
				end else begin
					wr.key_we   = 1'b1;
					wr.cnt_we   = 1'b1;
					wr.addr     = total_q[IDX_W-1:0];
					wr.key      = key_q;
					wr.count    = add_q;
					out_count_d = add_q;
					total_d     = total_q + TOT_W'(1);
				end
			end
			S_FLUSH_RD: state_d = S_FLUSH_EMIT;
			S_FLUSH_EMIT: begin
				out_load    = 1'b1;
				out_key_d   = rd_key;
				out_count_d = rd_count;
				last_d      = at_end;
				if (at_end) begin
					total_d = '0;
				end
				state_d = S_OUT;
			end
			S_OUT: begin
				if (rsp.ready) begin
					if (cmd_q == CMD_FLUSH && !last_q) begin
						idx_d   = idx_q + IDX_W'(1);
						state_d = S_FLUSH_RD;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			total_q <= total_d;
		end
	end

	// latched request beat
	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q <= cmd_t'(req.command);
			key_q <= req.key;
			add_q <= (req.command == CMD_COUNT) ? CNT_W'(1) : req.amount;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q    <= status_d;
			out_key_q   <= out_key_d;
			out_count_q <= out_count_d;
			last_q      <= last_d;
		end
	end

endmodule

[tb/tb_key_occurrence_counter.sv]
// Self-checking testbench for key_occurrence_counter: directed and random
// count, merge and flush beats checked against an in-bench histogram model.
// Depends on koc_pkg, koc_req_if, koc_rsp_if and the key_occurrence_counter RTL.
`timescale 1ns / 1ps

module tb_key_occurrence_counter import koc_pkg::*; ;

	// command code the block ignores
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_CYCLES = 200;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_BEATS = 250;

	typedef struct {
		logic [1:0]              command;
		logic signed [KEY_W-1:0] key;
		logic [CNT_W-1:0]        amount;
	} req_beat_t;

	typedef struct {
		logic [1:0]              status;
		logic signed [KEY_W-1:0] out_key;
		logic [CNT_W-1:0]        out_count;
		logic                    last;
	} tally_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic rx_hold = 1'b0;

	koc_req_if req_ch ();
	koc_rsp_if rsp_ch ();

	key_occurrence_counter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #1 clk = ~clk;

	req_beat_t     pending_beats[$];
	tally_result_t expected_tallies[$];

	// histogram model state
	logic signed [KEY_W-1:0] model_keys[TABLE_DEPTH];
	logic [CNT_W-1:0]        model_counts[TABLE_DEPTH];
	int                      model_used = 0;

	int unsigned beats_accepted = 0;
	int unsigned cycle_count = 0;
	int          failures = 0;
	int          counted_beats = 0;

	task automatic note_failure(input string msg);
		if (failures < 10)
			$display("[%0t] ERROR: %s", $realtime, msg);
		failures++;
	endtask

	// Work out the results of one accepted beat and update the model.
	function automatic void predict_tally(input logic [1:0] c, input logic signed [KEY_W-1:0] k,
			input logic [CNT_W-1:0] a);
		tally_result_t r;
		logic [CNT_W-1:0] add;
		logic [CNT_W:0]   sum;
		int               idx;
		idx = -1;
		if (c == CMD_FLUSH) begin
			if (model_used == 0) begin
				r = '{STAT_EMPTY, '0, '0, 1'b1};
				expected_tallies.push_back(r);
			end else begin
				for (int i = 0; i < model_used; i++) begin
					r = '{STAT_OK, model_keys[i], model_counts[i], (i == model_used - 1)};
					expected_tallies.push_back(r);
				end
				model_used = 0;
			end
		end else if (c == CMD_COUNT || c == CMD_MERGE) begin
			add = (c == CMD_COUNT) ? CNT_W'(1) : a;
			for (int i = 0; i < model_used; i++) begin
				if (idx < 0 && model_keys[i] == k)
					idx = i;
			end
			if (idx >= 0) begin
				// hit: saturating add
				sum = {1'b0, model_counts[idx]} + {1'b0, add};
				if (sum > {1'b0, CNT_MAX}) begin
					model_counts[idx] = CNT_MAX;
					r = '{STAT_SAT, k, CNT_MAX, 1'b1};
				end else begin
					model_counts[idx] = sum[CNT_W-1:0];
					r = '{STAT_OK, k, sum[CNT_W-1:0], 1'b1};
				end
			end else if (model_used >= TABLE_DEPTH) begin
				r = '{STAT_FULL, k, '0, 1'b1};
			end else begin
				model_keys[model_used] = k;
				model_counts[model_used] = add;
				model_used++;
				r = '{STAT_OK, k, add, 1'b1};
			end
			expected_tallies.push_back(r);
		end
	endfunction

	function automatic int unsigned sender_idle_pct();
		if (beats_accepted < 100)
			return 13;
		else if (beats_accepted < 200)
			return 61;
		return 0;
	endfunction

	function automatic int unsigned receiver_idle_pct();
		if (beats_accepted < 100)
			return 61;
		else if (beats_accepted < 200)
			return 13;
		return 0;
	endfunction

	task automatic add_beat(input logic [1:0] c, input logic [KEY_W-1:0] k,
			input logic [CNT_W-1:0] a);
		req_beat_t b;
		b = '{c, k, a};
		pending_beats.push_back(b);
		if (c != CMD_UNUSED)
			counted_beats++;
	endtask

	function automatic logic [CNT_W-1:0] pick_amount();
		case ($urandom_range(3))
			0: return '0;
			1: return CNT_W'($urandom_range(1, 100));
			2: return CNT_MAX - CNT_W'($urandom_range(0, 3));
			default: return CNT_W'($urandom());
		endcase
	endfunction

	// Request driver: predicts on acceptance, then offers the next beat.
	always @(posedge clk or negedge arst_n) begin : req_driver
		req_beat_t nxt;
		logic      holding;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			holding = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				predict_tally(req_ch.command, req_ch.key, req_ch.amount);
				beats_accepted <= beats_accepted + 1;
				holding = 1'b0;
			end
			if (!holding) begin
				if (pending_beats.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
					nxt = pending_beats.pop_front();
					req_ch.valid   <= 1'b1;
					req_ch.command <= nxt.command;
					req_ch.key     <= nxt.key;
					req_ch.amount  <= nxt.amount;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result ready: random idling, forced low during the long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= !rx_hold && ($urandom_range(99) >= receiver_idle_pct());
	end

	// Result monitor: compare each beat with the oldest expectation
	always @(posedge clk) begin : rsp_monitor
		tally_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_tallies.size() == 0) begin
				note_failure($sformatf("unexpected result status=%0d key=%h count=%h last=%b",
					rsp_ch.status, rsp_ch.out_key, rsp_ch.out_count, rsp_ch.last));
			end else begin
				want = expected_tallies.pop_front();
				if (rsp_ch.status !== want.status || rsp_ch.out_key !== want.out_key ||
						rsp_ch.out_count !== want.out_count || rsp_ch.last !== want.last)
					note_failure($sformatf({"result mismatch: ",
						"exp status=%0d key=%h count=%h last=%b, ",
						"got status=%0d key=%h count=%h last=%b"},
						want.status, want.out_key, want.out_count, want.last,
						rsp_ch.status, rsp_ch.out_key, rsp_ch.out_count, rsp_ch.last));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Long receiver hold-off while the sender keeps offering
	initial begin
		wait (beats_accepted >= 30);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Stimulus, reset and end of run
	initial begin : stimulus
		logic [KEY_W-1:0] key_pool[8];
		logic [KEY_W-1:0] first_fill;
		int               seq_no;
		int               kind;
		int               len;
		int               target;

		req_ch.valid = 1'b0;
		req_ch.command = CMD_COUNT;
		req_ch.key = '0;
		req_ch.amount = '0;
		rsp_ch.ready = 1'b0;

		// directed: empty flush, key extremes, merge of zero, exact max, saturation
		add_beat(CMD_FLUSH, 32'h0000_0000, '0);
		add_beat(CMD_COUNT, 32'h0000_0000, '0);
		add_beat(CMD_COUNT, 32'h7FFF_FFFF, '0);
		add_beat(CMD_COUNT, 32'h8000_0000, '0);
		add_beat(CMD_COUNT, 32'hFFFF_FFFF, '0);
		add_beat(CMD_COUNT, 32'h0000_0000, CNT_MAX);
		add_beat(CMD_MERGE, 32'h1234_5678, '0);
		add_beat(CMD_MERGE, 32'h1234_5678, '0);
		add_beat(CMD_MERGE, 32'h7FFF_FFFF, CNT_MAX - CNT_W'(1));
		add_beat(CMD_COUNT, 32'h7FFF_FFFF, '0);
		add_beat(CMD_MERGE, 32'h8000_0000, CNT_MAX);
		add_beat(CMD_MERGE, 32'hFFFF_FFFF, 31'h5555_5555);
		add_beat(CMD_COUNT, 32'hAAAA_AAAA, CNT_MAX);
		add_beat(CMD_UNUSED, 32'hFFFF_FFFF, CNT_MAX);
		add_beat(CMD_MERGE, 32'h5555_5555, CNT_MAX);
		add_beat(CMD_FLUSH, 32'hFFFF_FFFF, CNT_MAX);
		add_beat(CMD_FLUSH, 32'h0000_0000, '0);
		add_beat(CMD_UNUSED, 32'h0000_0000, '0);
		add_beat(CMD_MERGE, 32'hAAAA_AAAA, 31'h2AAA_AAAA);
		add_beat(CMD_FLUSH, 32'h5555_5555, 31'h2AAA_AAAA);

		// random: mostly bursts on a small key pool so that hits dominate
		foreach (key_pool[i])
			key_pool[i] = $urandom();
		target = counted_beats + RANDOM_BEATS;
		seq_no = 0;
		while (counted_beats < target) begin
			kind = $urandom_range(99);
			if (seq_no == 2 || kind < 4) begin
				// flush, fill the table, overflow it, hit old entries, then flush again
				add_beat(CMD_FLUSH, $urandom(), CNT_W'($urandom()));
				first_fill = $urandom();
				add_beat(CMD_COUNT, first_fill, CNT_W'($urandom()));
				for (int n = 1; n < TABLE_DEPTH + 3; n++)
					add_beat(($urandom_range(1) != 0) ? CMD_COUNT : CMD_MERGE, $urandom(),
						pick_amount());
				add_beat(CMD_COUNT, first_fill, CNT_W'($urandom()));
				add_beat(CMD_MERGE, first_fill, pick_amount());
				add_beat(CMD_FLUSH, $urandom(), CNT_W'($urandom()));
			end else if (kind < 55) begin
				key_pool[$urandom_range(7)] = $urandom();
				len = $urandom_range(5, 15);
				for (int n = 0; n < len; n++)
					add_beat(($urandom_range(2) != 0) ? CMD_COUNT : CMD_MERGE,
						key_pool[$urandom_range(7)], pick_amount());
			end else if (kind < 70) begin
				add_beat(CMD_FLUSH, $urandom(), CNT_W'($urandom()));
			end else if (kind < 82) begin
				// noise: ignored command or a stray key
				if ($urandom_range(1) != 0)
					add_beat(CMD_UNUSED, $urandom(), CNT_W'($urandom()));
				else
					add_beat(CMD_COUNT, $urandom(), CNT_W'($urandom()));
			end else begin
				// large merges on pool keys to reach saturation
				len = $urandom_range(2, 6);
				for (int n = 0; n < len; n++)
					add_beat(CMD_MERGE, key_pool[$urandom_range(3)],
						CNT_MAX - CNT_W'($urandom_range(0, 1000)));
			end
			seq_no++;
		end
		add_beat(CMD_FLUSH, $urandom(), CNT_W'($urandom()));

		// reset
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// drain
		wait (pending_beats.size() == 0 && !req_ch.valid && expected_tallies.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_tallies.size() != 0)
			note_failure($sformatf("%0d expected results never arrived",
				expected_tallies.size()));

		if (failures == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
